/* hw/rtl/easing_curve_interpolator_defines.svh */
// Assertion macros shared by the easing curve interpolator RTL.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef EASING_CURVE_INTERPOLATOR_DEFINES_SVH
`define EASING_CURVE_INTERPOLATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ECI_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("easing interpolator check failed");

// The consequent must hold after the antecedent, delayed by dly.
`define ECI_ASSERT_DELAY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##dly (cons)) \
    else $error("easing interpolator latency check failed");

`endif

/* hw/rtl/eci_pkg.sv */
`default_nettype none
package eci_pkg;

  localparam int unsigned FracBits = 16;
  localparam logic [16:0] OneFx = 17'(1) << FracBits;
  localparam logic [17:0] TwoFx = 18'(2) << FracBits;

  // Square root of a radicand below 2^34, one result bit per step.
  localparam int unsigned SqSteps = 17;
  localparam int unsigned SqStepsPerStage = 3;
  localparam int unsigned SqStages = (SqSteps + SqStepsPerStage - 1) / SqStepsPerStage;

  typedef enum logic [3:0] {
    ModeLinear     = 4'd0,
    ModeQuadIn     = 4'd1,
    ModeQuadOut    = 4'd2,
    ModeQuadInOut  = 4'd3,
    ModeCircIn     = 4'd4,
    ModeCircOut    = 4'd5,
    ModeCircInOut  = 4'd6,
    ModeExpIn      = 4'd7,
    ModeExpOut     = 4'd8,
    ModeExpInOut   = 4'd9
  } ease_mode_e;

  // Data that rides along the pipeline stages up to stage 11.
  typedef struct packed {
    logic [3:0]         mode;
    logic               hi;
    logic signed [31:0] start;
    logic signed [31:0] delta;
    logic [16:0]        e;
  } carry_t;

  typedef struct packed {
    logic [34:0] rem;
    logic [34:0] res;
  } sq_state_t;

  // 2^(-k/16) in Q1.30.
  function automatic logic [30:0] pow2_tab(input logic [4:0] k);
    logic [30:0] v;
    unique case (k)
      5'd0:  v = 31'd1073741824;
      5'd1:  v = 31'd1028218693;
      5'd2:  v = 31'd984625594;
      5'd3:  v = 31'd942880699;
      5'd4:  v = 31'd902905651;
      5'd5:  v = 31'd864625413;
      5'd6:  v = 31'd827968132;
      5'd7:  v = 31'd792865000;
      5'd8:  v = 31'd759250125;
      5'd9:  v = 31'd727060411;
      5'd10: v = 31'd696235435;
      5'd11: v = 31'd666717336;
      5'd12: v = 31'd638450708;
      5'd13: v = 31'd611382493;
      5'd14: v = 31'd585461881;
      5'd15: v = 31'd560640218;
      default: v = 31'd536870912;
    endcase
    return v;
  endfunction

  // One restoring square root step with the trial bit 2^(32 - 2*step).
  function automatic sq_state_t sq_step(input sq_state_t s, input int unsigned step);
    sq_state_t o;
    logic [34:0] bit_v;
    logic [34:0] trial;
    bit_v = 35'(1) << (32 - 2 * step);
    trial = s.res + bit_v;
    if (s.rem >= trial) begin
      o.rem = s.rem - trial;
      o.res = (s.res >> 1) + bit_v;
    end else begin
      o.rem = s.rem;
      o.res = s.res >> 1;
    end
    return o;
  endfunction

  function automatic logic [16:0] fx_half(input logic [17:0] x);
    logic [18:0] s;
    s = {1'b0, x} + 19'd1;
    return s[17:1];
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/easing_curve_interpolator.sv */
`default_nettype none
// Easing curve interpolator.
// A transaction is accepted at a rising edge with start high and busy
// low. It carries start_value_i and change_amount_i (signed Q15.16) and
// progress_i (unsigned Q1.16, values above 1.0 are clamped to 1.0). The
// result eased_value_o = start + change * e(progress), saturated to 32 bits,
// appears for exactly one cycle with eased_valid_o high, out of the last
// stage register. busy is always low: a new transaction may enter every
// cycle and the sustained rate is one per clock.
// The receiver cannot stall, and nothing inside the block ever waits.
// The curve is picked by ease_mode_i, written when ease_mode_we_i is high.
// Each transaction captures the mode on entry, so writes only matter for
// later transactions. Codes 10 to 15 act as linear.
// Pipeline depth is set by the square root: 17 result bits, three per stage
// over six stages, plus table lookup, three multiplies and final rounding.
// Reset clears the mode to linear and empties the pipeline; no result is
// pending after reset.
module easing_curve_interpolator
  import eci_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               ease_mode_we_i,
  input  wire logic [3:0]         ease_mode_i,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] start_value_i,
  input  wire logic signed [31:0] change_amount_i,
  input  wire logic [16:0]        progress_i,
  output logic                    eased_valid_o,
  output logic signed [31:0]      eased_value_o
);

`include "easing_curve_interpolator_defines.svh"

  localparam int unsigned Latency = 13;

  logic [3:0] mode_q;
  logic       accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeLinear;
    end else if (ease_mode_we_i) begin
      mode_q <= ease_mode_i;
    end
  end

  // Valid bits, one per stage. Index k is stage k+1.
  logic [Latency-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Latency-2:0], accept};
    end
  end

  // Stage 1: capture the transaction and clamp the progress.
  carry_t      c1_q;
  logic [16:0] t1_q;
  always_ff @(posedge clk_i) begin
    c1_q.mode  <= mode_q;
    c1_q.hi    <= 1'b0;
    c1_q.start <= start_value_i;
    c1_q.delta <= change_amount_i;
    c1_q.e     <= '0;
    t1_q       <= (progress_i > OneFx) ? OneFx : progress_i;
  end

  // Stage 2: pick the multiplier operands and the exponent argument.
  logic [17:0] tt2, ta2, mul_a2_d, mul_b2_d;
  logic [16:0] xe2;
  logic [19:0] earg2_d;
  logic        hi2;
  carry_t      c2_d, c2_q;
  logic [17:0] mul_a2_q, mul_b2_q;
  logic [19:0] earg2_q;

  always_comb begin
    tt2 = {t1_q, 1'b0};
    hi2 = tt2 >= {1'b0, OneFx};
    ta2 = {1'b0, t1_q};
    mul_a2_d = '0;
    mul_b2_d = '0;
    xe2 = '0;
    unique case (c1_q.mode)
      ModeQuadIn, ModeCircIn: begin
        mul_a2_d = ta2;
        mul_b2_d = ta2;
      end
      ModeQuadOut: begin
        mul_a2_d = ta2;
        mul_b2_d = TwoFx - ta2;
      end
      ModeQuadInOut: begin
        if (hi2) begin
          mul_a2_d = tt2 - {1'b0, OneFx};
          mul_b2_d = TwoFx - (tt2 - {1'b0, OneFx});
        end else begin
          mul_a2_d = tt2;
          mul_b2_d = tt2;
        end
      end
      ModeCircOut: begin
        mul_a2_d = {1'b0, OneFx} - ta2;
        mul_b2_d = {1'b0, OneFx} - ta2;
      end
      ModeCircInOut: begin
        if (hi2) begin
          mul_a2_d = TwoFx - tt2;
          mul_b2_d = TwoFx - tt2;
        end else begin
          mul_a2_d = tt2;
          mul_b2_d = tt2;
        end
      end
      ModeExpIn:  xe2 = OneFx - t1_q;
      ModeExpOut: xe2 = t1_q;
      ModeExpInOut: begin
        if (hi2) begin
          xe2 = 17'(tt2 - {1'b0, OneFx});
        end else begin
          xe2 = 17'({1'b0, OneFx} - tt2);
        end
      end
      default: ;
    endcase
    // Ten times the argument, as two shifts.
    earg2_d = ({3'b0, xe2} << 3) + ({3'b0, xe2} << 1);
    c2_d = c1_q;
    c2_d.hi = hi2;
    c2_d.e  = t1_q;
  end

  always_ff @(posedge clk_i) begin
    c2_q     <= c2_d;
    mul_a2_q <= mul_a2_d;
    mul_b2_q <= mul_b2_d;
    earg2_q  <= earg2_d;
  end

  // Stage 3: square-type multiply and the power-of-two table lookup.
  logic [35:0] prod3;
  logic [3:0]  n3;
  logic [4:0]  idx3;
  logic [30:0] tab_lo3;
  logic [17:0] m3_q;
  logic [30:0] tab3_q, dif3_q;
  logic [11:0] r3_q;
  logic [3:0]  n3_q;
  carry_t      c3_q;

  always_comb begin
    prod3   = mul_a2_q * mul_b2_q + 36'(1 << (FracBits - 1));
    n3      = (earg2_q[19:16] > 4'd10) ? 4'd10 : earg2_q[19:16];
    idx3    = {1'b0, earg2_q[15:12]};
    tab_lo3 = pow2_tab(idx3 + 5'd1);
  end

  always_ff @(posedge clk_i) begin
    c3_q   <= c2_q;
    m3_q   <= prod3[33:16];
    tab3_q <= pow2_tab(idx3);
    dif3_q <= pow2_tab(idx3) - tab_lo3;
    r3_q   <= earg2_q[11:0];
    n3_q   <= n3;
  end

  // Stage 4: quadratic results, square root setup, interpolation product.
  carry_t      c4_d;
  sq_state_t   sq_d [SqStages+1];
  sq_state_t   sq_q [SqStages+1];
  carry_t      cq   [SqStages+1];
  logic [42:0] ip4_q;
  logic [30:0] tab4_q;
  logic [3:0]  n4_q;
  logic [16:0] rad4;

  always_comb begin
    c4_d = c3_q;
    unique case (c3_q.mode)
      ModeQuadIn, ModeQuadOut: c4_d.e = m3_q[16:0];
      ModeQuadInOut: begin
        if (c3_q.hi) begin
          c4_d.e = fx_half({1'b0, OneFx} + m3_q);
        end else begin
          c4_d.e = fx_half(m3_q);
        end
      end
      default: ;
    endcase
    rad4 = OneFx - m3_q[16:0];
    sq_d[0].rem = {2'b0, rad4, 16'b0};
    sq_d[0].res = '0;
  end

  always_ff @(posedge clk_i) begin
    cq[0]   <= c4_d;
    sq_q[0] <= sq_d[0];
    ip4_q   <= dif3_q * r3_q;
    tab4_q  <= tab3_q;
    n4_q    <= n3_q;
  end

  // Exponential result, folded into the first square root stage.
  logic [30:0] v5;
  logic [4:0]  s5;
  logic [31:0] vr5;
  logic [16:0] pe5;
  carry_t      c5_d;

  always_comb begin
    v5  = tab4_q - 31'(ip4_q >> (FracBits - 4));
    s5  = 5'(30 - FracBits) + {1'b0, n4_q};
    vr5 = ({1'b0, v5} + (32'd1 << (s5 - 5'd1))) >> s5;
    pe5 = vr5[16:0];
    c5_d = cq[0];
    unique case (cq[0].mode)
      ModeExpIn:  c5_d.e = pe5;
      ModeExpOut: c5_d.e = OneFx - pe5;
      ModeExpInOut: begin
        if (cq[0].hi) begin
          c5_d.e = fx_half(TwoFx - {1'b0, pe5});
        end else begin
          c5_d.e = fx_half({1'b0, pe5});
        end
      end
      default: ;
    endcase
  end

  // Square root stages.
  for (genvar k = 0; k < SqStages; k++) begin : g_sq
    always_comb begin
      sq_d[k+1] = sq_q[k];
      for (int unsigned i = 0; i < SqStepsPerStage; i++) begin
        if (k * SqStepsPerStage + i < SqSteps) begin
          sq_d[k+1] = sq_step(sq_d[k+1], k * SqStepsPerStage + i);
        end
      end
    end
    always_ff @(posedge clk_i) begin
      sq_q[k+1] <= sq_d[k+1];
      cq[k+1]   <= (k == 0) ? c5_d : cq[k];
    end
  end

  // Stage 11: round the root and finish the circular curves.
  logic [34:0] root11;
  logic [16:0] sq11;
  carry_t      c11_d, c11_q;

  always_comb begin
    root11 = sq_q[SqStages].res + 35'(sq_q[SqStages].rem > sq_q[SqStages].res);
    sq11   = root11[16:0];
    c11_d  = cq[SqStages];
    unique case (cq[SqStages].mode)
      ModeCircIn:  c11_d.e = OneFx - sq11;
      ModeCircOut: c11_d.e = sq11;
      ModeCircInOut: begin
        if (cq[SqStages].hi) begin
          c11_d.e = fx_half({1'b0, sq11} + {1'b0, OneFx});
        end else begin
          c11_d.e = fx_half({1'b0, OneFx - sq11});
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    c11_q <= c11_d;
  end

  // Stage 12: scale the change amount.
  logic signed [49:0] p12_q;
  logic signed [31:0] start12_q;
  logic [16:0]        e12_q;

  always_ff @(posedge clk_i) begin
    p12_q     <= 50'(c11_q.delta) * 50'($signed({1'b0, c11_q.e}));
    start12_q <= c11_q.start;
    e12_q     <= c11_q.e;
  end

  // Stage 13: round, add and saturate.
  logic signed [49:0] pr13;
  logic signed [33:0] q13;
  logic signed [34:0] sum13;
  logic signed [31:0] out13_d, out13_q;

  always_comb begin
    pr13  = p12_q + 50'sd32768;
    q13   = 34'(pr13 >>> FracBits);
    sum13 = 35'(start12_q) + 35'(q13);
    if (sum13 > 35'sd2147483647) begin
      out13_d = 32'sh7fffffff;
    end else if (sum13 < -35'sd2147483648) begin
      out13_d = 32'sh80000000;
    end else begin
      out13_d = sum13[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    out13_q <= out13_d;
  end

  assign eased_valid_o = vld_q[Latency-1];
  assign eased_value_o = out13_q;

  `ECI_ASSERT_DELAY(a_latency, accept, 13, eased_valid_o)
  `ECI_ASSERT_SAME(a_factor_range, vld_q[Latency-2], e12_q <= OneFx)
  `ECI_ASSERT_SAME(a_root_range, vld_q[Latency-4], sq11 <= OneFx)
  `ECI_ASSERT_SAME(a_exp_range, vld_q[3], pe5 <= OneFx)

endmodule
`default_nettype wire

/* tb/easing_curve_interpolator_tb.sv */
`default_nettype none
// Self-checking bench for the easing curve interpolator.
// A queue of pending work holds input transactions and mode writes in
// program order. A clocked driver takes them from the queue. A clocked
// monitor checks each result against the oldest predicted value.
module easing_curve_interpolator_tb;
  import eci_pkg::*;

  localparam longint unsigned One = 64'd1 << FracBits;
  // Settle longer than the block takes to answer after accepting.
  localparam int SettleCycles = 24;
  localparam int StallLimit   = 5000;

  // One entry of pending work: either a mode write or an input transaction.
  typedef struct {
    bit                 is_mode_write;
    logic [3:0]         mode;
    logic signed [31:0] start_val;
    logic signed [31:0] change;
    logic [16:0]        prog;
  } work_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               ease_mode_we_i = 1'b0;
  logic [3:0]         ease_mode_i = 4'd0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] start_value_i = 32'sd0;
  logic signed [31:0] change_amount_i = 32'sd0;
  logic [16:0]        progress_i = 17'd0;
  logic               eased_valid_o;
  logic signed [31:0] eased_value_o;

  work_t              pending_work[$];
  logic signed [31:0] expected_values[$];
  logic [3:0]         curve_mode;   // the mode that the block holds now
  int                 errors = 0;
  int                 n_sent = 0;
  int                 n_checked = 0;
  int                 n_settings = 0;
  int                 quiet_cycles = 0;
  int                 stall_cycles = 0;

  // 2^(-k/16) in Q1.30, for k from 0 to 16.
  longint unsigned exp_steps[17] = '{
    1073741824, 1028218693, 984625594, 942880699, 902905651,
    864625413, 827968132, 792865000, 759250125, 727060411,
    696235435, 666717336, 638450708, 611382493, 585461881,
    560640218, 536870912};

  easing_curve_interpolator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ease_mode_we_i (ease_mode_we_i),
    .ease_mode_i    (ease_mode_i),
    .start          (start),
    .busy           (busy),
    .start_value_i  (start_value_i),
    .change_amount_i(change_amount_i),
    .progress_i     (progress_i),
    .eased_valid_o  (eased_valid_o),
    .eased_value_o  (eased_value_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Fixed-point product of two fractions, rounded to nearest.
  function automatic longint unsigned frac_product(longint unsigned a, longint unsigned b);
    return (a * b + (One >> 1)) >> FracBits;
  endfunction

  function automatic longint unsigned halve(longint unsigned x);
    return (x + 1) >> 1;
  endfunction

  // Square root of a fraction: bit-serial restoring root of x << FracBits,
  // rounded up by one when the remainder exceeds the root.
  function automatic longint unsigned frac_root(longint unsigned x);
    longint unsigned radicand;
    longint unsigned root;
    longint unsigned trial;
    radicand = x << FracBits;
    root = 0;
    trial = 64'd1 << 50;
    for (int i = 0; i < 26; i++) begin
      if (radicand >= root + trial) begin
        radicand -= root + trial;
        root = (root >> 1) + trial;
      end else begin
        root >>= 1;
      end
      trial >>= 2;
    end
    if (radicand > root) root += 1;
    return root;
  endfunction

  // 2^-a for a fixed-point exponent a. The table is indexed by the top four
  // fraction bits, and the rest of the fraction interpolates linearly.
  function automatic longint unsigned neg_power_of_two(longint unsigned a);
    longint unsigned whole;
    longint unsigned frac;
    longint unsigned idx;
    longint unsigned rest;
    longint unsigned v;
    longint unsigned sh;
    whole = a >> FracBits;
    frac  = a & (One - 1);
    idx   = frac >> (FracBits - 4);
    rest  = frac & ((64'd1 << (FracBits - 4)) - 1);
    if (whole > 10) whole = 10;
    v  = exp_steps[idx] - (((exp_steps[idx] - exp_steps[idx + 1]) * rest) >> (FracBits - 4));
    sh = 30 - FracBits + whole;
    return (v + (64'd1 << (sh - 1))) >> sh;
  endfunction

  // Easing factor e(t) for the given curve. In-out curves split at t = 0.5.
  function automatic longint unsigned curve_factor(logic [3:0] mode, longint unsigned t);
    longint unsigned tt;
    longint unsigned u;
    tt = t << 1;
    case (mode)
      ModeQuadIn:  return frac_product(t, t);
      ModeQuadOut: return frac_product(t, 2 * One - t);
      ModeQuadInOut: begin
        if (tt < One) return halve(frac_product(tt, tt));
        tt -= One;
        return halve(One + frac_product(tt, 2 * One - tt));
      end
      ModeCircIn:  return One - frac_root(One - frac_product(t, t));
      ModeCircOut: begin
        u = One - t;
        return frac_root(One - frac_product(u, u));
      end
      ModeCircInOut: begin
        if (tt < One) return halve(One - frac_root(One - frac_product(tt, tt)));
        tt = 2 * One - tt;
        return halve(frac_root(One - frac_product(tt, tt)) + One);
      end
      ModeExpIn:  return neg_power_of_two(10 * (One - t));
      ModeExpOut: return One - neg_power_of_two(10 * t);
      ModeExpInOut: begin
        if (tt < One) return halve(neg_power_of_two(10 * (One - tt)));
        tt -= One;
        return halve(2 * One - neg_power_of_two(10 * tt));
      end
      // Linear, and the unused codes that fall back to linear.
      default: return t;
    endcase
  endfunction

  // start + change * e(t). The rounding is floor(p + one half), and the
  // sum saturates to the signed 32-bit range.
  function automatic logic signed [31:0] eased_point(logic [3:0] mode,
      logic signed [31:0] s, logic signed [31:0] d, logic [16:0] prog);
    longint unsigned t;
    longint          e;
    longint          p;
    longint          sum;
    t = prog;
    if (t > One) t = One;
    e = longint'(curve_factor(mode, t));
    p = longint'(d) * e + longint'(One >> 1);
    sum = longint'(s) + (p >>> FracBits);
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    return sum[31:0];
  endfunction

  // Driver. A transaction is taken when start is high and busy is low. The
  // next start or mode write is decided once per edge, so that every signal
  // gets one assignment per time step. Mode writes wait until every result
  // has come back and the pipeline has been quiet long enough to be empty.
  always @(posedge clk_i) begin
    bit    taken;
    bit    next_start;
    bit    next_we;
    work_t w;
    if (rst_ni) begin
      taken = start && !busy;
      next_start = start && !taken;
      next_we = 1'b0;
      if (taken) begin
        expected_values.push_back(eased_point(curve_mode, start_value_i,
                                              change_amount_i, progress_i));
        n_sent++;
      end
      if (ease_mode_we_i) curve_mode = ease_mode_i;
      if (taken || eased_valid_o) quiet_cycles = 0;
      else quiet_cycles++;
      if (!next_start && pending_work.size() > 0) begin
        if (pending_work[0].is_mode_write) begin
          if (!taken && expected_values.size() == 0 && quiet_cycles >= SettleCycles) begin
            w = pending_work.pop_front();
            next_we = 1'b1;
            ease_mode_i <= w.mode;
          end
        // Gaps at random, except for a long stretch with none at all.
        end else if ((n_sent >= 700 && n_sent < 1000) || $urandom_range(99) >= 22) begin
          w = pending_work.pop_front();
          next_start = 1'b1;
          start_value_i   <= w.start_val;
          change_amount_i <= w.change;
          progress_i      <= w.prog;
        end
      end
      start <= next_start;
      ease_mode_we_i <= next_we;
    end
  end

  // Monitor. Results cannot be held off, so each strobed result is checked
  // at the edge that ends its cycle. The watchdog runs here too.
  always @(posedge clk_i) begin
    logic signed [31:0] want;
    if (rst_ni) begin
      if (eased_valid_o) begin
        if (expected_values.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %0d",
                   $time, eased_value_o);
          errors++;
        end else begin
          want = expected_values.pop_front();
          if (eased_value_o !== want) begin
            $display("%0t: eased_value mismatch: expected %0d, actual %0d",
                     $time, want, eased_value_o);
            errors++;
          end
          n_checked++;
        end
      end
      if (eased_valid_o || (start && !busy)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: timeout, no transaction for %0d cycles", $time, StallLimit);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic logic [16:0] pick_progress();
    logic [16:0] corners[9] = '{17'h00000, 17'h00001, 17'h07FFF, 17'h08000,
                                17'h08001, 17'h0FFFF, 17'h10000, 17'h10001, 17'h1FFFF};
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 15) return corners[$urandom_range(8)];
    // Values above one are clamped by the block.
    if (roll < 25) return 17'($urandom_range(17'h1FFFF, 17'h10001));
    return 17'($urandom_range(17'h10000));
  endfunction

  function automatic logic signed [31:0] pick_operand();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
    if (roll < 50) return 32'($signed($urandom_range(32'h1FFFFF)) - 32'sh100000);
    return $urandom;
  endfunction

  task automatic queue_mode(logic [3:0] mode);
    work_t w;
    w.is_mode_write = 1'b1;
    w.mode = mode;
    w.start_val = 32'sd0;
    w.change = 32'sd0;
    w.prog = 17'd0;
    pending_work.push_back(w);
    n_settings++;
  endtask

  task automatic queue_point(logic signed [31:0] s, logic signed [31:0] d, logic [16:0] p);
    work_t w;
    w.is_mode_write = 1'b0;
    w.mode = 4'd0;
    w.start_val = s;
    w.change = d;
    w.prog = p;
    pending_work.push_back(w);
  endtask

  initial begin
    logic [3:0] mode;
    curve_mode = ModeLinear;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part in the reset mode: operand extremes, saturation both
    // ways, and progress at zero, one half, one, and above one.
    queue_point(32'sd0, 32'sd0, 17'h00000);
    queue_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 17'h10000);
    queue_point(32'sh80000000, 32'sh80000000, 17'h10000);
    queue_point(32'sh7FFFFFFF, 32'sh80000000, 17'h10000);
    queue_point(32'sh80000000, 32'sh7FFFFFFF, 17'h1FFFF);
    queue_point(32'sh00010000, 32'sh00640000, 17'h08000);
    queue_point(32'sh00000000, -32'sh00000001, 17'h00001);
    queue_point(32'sh00000000, 32'sh00000001, 17'h08000);
    queue_point(-32'sh00010000, 32'sh00010000, 17'h10001);
    queue_point(32'sh12345678, -32'sh7FFFFFFF, 17'h0FFFF);

    // Every curve and the unused codes in turn, then random settings.
    // Each phase opens with the edge points of the curve.
    for (int ph = 0; ph < 29; ph++) begin
      mode = (ph < 16) ? 4'(ph) : 4'($urandom_range(9));
      if (ph == 28) mode = ModeExpInOut;
      queue_mode(mode);
      queue_point(32'sd0, 32'sh00010000, 17'h00000);
      queue_point(32'sd0, 32'sh00010000, 17'h08000);
      queue_point(32'sd0, 32'sh00010000, 17'h10000);
      for (int i = 0; i < 50; i++) queue_point(pick_operand(), pick_operand(), pick_progress());
    end
    queue_mode(ModeLinear);
    for (int i = 0; i < 20; i++) queue_point(pick_operand(), pick_operand(), pick_progress());

    while (pending_work.size() != 0 || start || expected_values.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
    $display("Sent %0d transactions over %0d mode settings; %0d results checked.",
             n_sent, n_settings, n_checked);
    if (errors == 0 && expected_values.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
+incdir+hw/rtl
hw/rtl/eci_pkg.sv
hw/rtl/easing_curve_interpolator.sv
tb/easing_curve_interpolator_tb.sv
